// File: hdl/rlid_pkg.sv
// Shared widths, register indexes and parameter defaults for the run-length image decoder.
package rlid_pkg;

  localparam int ROW_W     = 5;
  localparam int COL_W     = 10;
  localparam int CNT_W     = 11;
  localparam int VAL_W     = 8;
  localparam int LEN_W     = 15;
  localparam int POS_W     = 16;
  localparam int CFG_W     = 11;
  localparam int REG_IDX_W = 2;
  localparam int SPAN_N_W  = 7;

  localparam int MAX_ROWS_DEF   = 30;
  localparam int MAX_COLS_DEF   = 1024;
  localparam int PIXEL_BITS_DEF = 8;

  localparam logic [SPAN_N_W-1:0] SPAN_MAX = SPAN_N_W'(64);

  localparam logic [REG_IDX_W-1:0] REG_NUM_ROWS = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_NUM_COLS = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MODE     = 2'd2;

  localparam logic CMD_RUN = 1'b0;
  localparam logic CMD_END = 1'b1;

endpackage

// File: hdl/rlid_ifs.sv
// Request and span channel interfaces of the run-length image decoder.
interface rlid_in_if;
  import rlid_pkg::*;
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [ROW_W-1:0] start_row;
  logic [COL_W-1:0] start_col;
  logic [VAL_W-1:0] pixel_value;
  logic [LEN_W-1:0] run_length;

  modport source (output valid, cmd, start_row, start_col, pixel_value, run_length,
                  input ready);
  modport sink (input valid, cmd, start_row, start_col, pixel_value, run_length,
                output ready);
endinterface

interface rlid_out_if;
  import rlid_pkg::*;
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] span_row;
  logic [COL_W-1:0] span_first_col;
  logic [CNT_W-1:0] span_count;
  logic [VAL_W-1:0] span_value;
  logic             row_end;
  logic             last;

  modport source (output valid, span_row, span_first_col, span_count, span_value, row_end,
                  last, input ready);
  modport sink (input valid, span_row, span_first_col, span_count, span_value, row_end,
                last, output ready);
endinterface

// File: hdl/run_length_image_decoder_unit.sv
// A request runs through the setup states NORM, CUR, TGT and GAP, then one span per cycle while out is ready.
// A new request is accepted only in the idle state, after the last span of the previous one is loaded.
// The setup runs the shared multiply-add unit twice (current and target linear position).
// Reset (synchronous, rst_n low): position and full flag clear, num_rows 1, num_cols 1,
// mode 0, sequencer idle and no span pending.
module run_length_image_decoder_unit #(
  parameter int MAX_ROWS   = rlid_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = rlid_pkg::MAX_COLS_DEF,
  parameter int PIXEL_BITS = rlid_pkg::PIXEL_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rlid_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [rlid_pkg::CFG_W-1:0]     cfg_wdata,
  rlid_in_if.sink                        in_chan,
  rlid_out_if.source                     out_chan
);
  import rlid_pkg::*;

  localparam int ColLimitI = (MAX_COLS < 1024) ? MAX_COLS : 1024;
  localparam logic [CNT_W-1:0] ColLimit = CNT_W'(ColLimitI);
  localparam logic [ROW_W-1:0] RowLimit = ROW_W'(MAX_ROWS);
  localparam int ValBits = (PIXEL_BITS < VAL_W) ? PIXEL_BITS : VAL_W;
  localparam logic [VAL_W-1:0] ValMask = VAL_W'((1 << ValBits) - 1);

  typedef enum logic [2:0] {S_IDLE, S_NORM, S_CUR, S_TGT, S_GAP, S_EMIT} state_t;

  state_t              state_r;
  logic [ROW_W-1:0]    num_rows_r;
  logic [CNT_W-1:0]    num_cols_r;
  logic                mode_r;

  logic [ROW_W-1:0]    row_r;
  logic [COL_W-1:0]    col_r;
  logic                full_r;

  logic                cmd_r;
  logic [ROW_W-1:0]    srow_r;
  logic [COL_W-1:0]    scol_r;
  logic [VAL_W-1:0]    val_r;
  logic [LEN_W-1:0]    len_r;

  logic [POS_W-1:0]    acc_r;
  logic [POS_W-1:0]    cur_r;
  logic [POS_W-1:0]    cnt_r;
  logic                zero_r;
  logic                gap_r;
  logic [SPAN_N_W-1:0] n_r;

  logic                out_valid_r;
  logic [ROW_W-1:0]    out_row_r;
  logic [COL_W-1:0]    out_col_r;
  logic [CNT_W-1:0]    out_cnt_r;
  logic [VAL_W-1:0]    out_val_r;
  logic                out_row_end_r;
  logic                out_last_r;

  logic [ROW_W-1:0]    rows_eff;
  logic [CNT_W-1:0]    cols_eff;

  // shared multiply-add unit
  logic [ROW_W-1:0]    mul_a;
  logic [COL_W-1:0]    mul_c;
  logic [POS_W-1:0]    mul_res;

  logic [CNT_W-1:0]    room;
  logic [CNT_W-1:0]    take;
  logic [POS_W-1:0]    rem;
  logic [CNT_W-1:0]    col_sum;
  logic                span_row_end;
  logic [ROW_W-1:0]    row_inc;
  logic                full_new;
  logic [SPAN_N_W-1:0] n_inc;
  logic                more_here;
  logic                more_run;
  logic                span_last;
  logic                load_en;
  logic                norm_wrap;

  always_comb begin
    rows_eff = (num_rows_r > RowLimit) ? RowLimit : num_rows_r;
    cols_eff = (num_cols_r > ColLimit) ? ColLimit : num_cols_r;
    if (cols_eff == '0) begin
      cols_eff = CNT_W'(1);
    end
  end

  always_comb begin
    if (state_r == S_CUR) begin
      mul_a = row_r;
      mul_c = col_r;
    end else if (cmd_r == CMD_END) begin
      mul_a = rows_eff;
      mul_c = '0;
    end else begin
      mul_a = srow_r;
      mul_c = scol_r;
    end
    mul_res = POS_W'(mul_a) * POS_W'(cols_eff) + POS_W'(mul_c);
  end

  assign norm_wrap = ({1'b0, col_r} >= cols_eff);

  // one span per cycle while out is ready: clip the remaining count at the row end
  always_comb begin
    room         = cols_eff - {1'b0, col_r};
    take         = (cnt_r < POS_W'(room)) ? cnt_r[CNT_W-1:0] : room;
    rem          = cnt_r - POS_W'(take);
    col_sum      = {1'b0, col_r} + take;
    span_row_end = (col_sum == cols_eff);
    row_inc      = row_r + ROW_W'(1);
    full_new     = span_row_end && (row_inc >= rows_eff);
    n_inc        = n_r + SPAN_N_W'(1);
    more_here    = (rem != '0) && !full_new && (n_inc != SPAN_MAX);
    more_run     = gap_r && (len_r != '0) && !full_new && (n_inc != SPAN_MAX);
    span_last    = !(more_here || more_run);
  end

  assign load_en = (state_r == S_EMIT) && (!out_valid_r || out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      num_rows_r  <= ROW_W'(1);
      num_cols_r  <= CNT_W'(1);
      mode_r      <= 1'b0;
      row_r       <= '0;
      col_r       <= '0;
      full_r      <= 1'b0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_NUM_ROWS: num_rows_r <= cfg_wdata[ROW_W-1:0];
          REG_NUM_COLS: num_cols_r <= cfg_wdata;
          REG_MODE:     mode_r     <= cfg_wdata[0];
          default: ;
        endcase
      end

      if (out_valid_r && out_chan.ready && !load_en) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            cmd_r   <= in_chan.cmd;
            srow_r  <= in_chan.start_row;
            scol_r  <= in_chan.start_col;
            val_r   <= in_chan.pixel_value & ValMask;
            len_r   <= in_chan.run_length;
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          // a column left past the row end by a width change wraps to the next row
          if (norm_wrap) begin
            col_r  <= '0;
            row_r  <= row_inc;
            full_r <= full_r || (row_inc >= rows_eff);
          end else begin
            full_r <= full_r || (row_r >= rows_eff);
          end
          state_r <= S_CUR;
        end
        S_CUR: begin
          acc_r   <= mul_res;
          state_r <= S_TGT;
        end
        S_TGT: begin
          cur_r   <= acc_r;
          acc_r   <= mul_res;
          state_r <= S_GAP;
        end
        S_GAP: begin
          n_r <= '0;
          if (full_r) begin
            if (cmd_r == CMD_END) begin
              row_r  <= '0;
              col_r  <= '0;
              full_r <= 1'b0;
            end
            state_r <= S_IDLE;
          end else if (cmd_r == CMD_END) begin
            cnt_r   <= acc_r - cur_r;
            zero_r  <= 1'b1;
            gap_r   <= 1'b0;
            state_r <= S_EMIT;
          end else if (mode_r && (acc_r > cur_r)) begin
            cnt_r   <= acc_r - cur_r;
            zero_r  <= 1'b1;
            gap_r   <= 1'b1;
            state_r <= S_EMIT;
          end else if (len_r != '0) begin
            cnt_r   <= POS_W'(len_r);
            zero_r  <= 1'b0;
            gap_r   <= 1'b0;
            state_r <= S_EMIT;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (load_en) begin
            out_valid_r   <= 1'b1;
            out_row_r     <= row_r;
            out_col_r     <= col_r;
            out_cnt_r     <= take;
            out_val_r     <= zero_r ? '0 : val_r;
            out_row_end_r <= span_row_end;
            out_last_r    <= span_last;
            n_r           <= n_inc;
            if (span_last && (cmd_r == CMD_END)) begin
              // end of image: rewind for the next one
              row_r  <= '0;
              col_r  <= '0;
              full_r <= 1'b0;
            end else begin
              col_r  <= span_row_end ? '0 : col_sum[COL_W-1:0];
              row_r  <= span_row_end ? row_inc : row_r;
              full_r <= full_new;
            end
            if (more_here) begin
              cnt_r <= rem;
            end else if (more_run) begin
              cnt_r  <= POS_W'(len_r);
              zero_r <= 1'b0;
              gap_r  <= 1'b0;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_chan.ready           = (state_r == S_IDLE);
  assign out_chan.valid          = out_valid_r;
  assign out_chan.span_row       = out_row_r;
  assign out_chan.span_first_col = out_col_r;
  assign out_chan.span_count     = out_cnt_r;
  assign out_chan.span_value     = out_val_r;
  assign out_chan.row_end        = out_row_end_r;
  assign out_chan.last           = out_last_r;

  // a span that is not the last of its request leaves the sequencer busy
  a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.last |-> state_r == S_EMIT)
    else $error("span without last flag while sequencer idle");

  // a span stays inside one row
  a_span_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> ({1'b0, out_chan.span_first_col} + out_chan.span_count) <= cols_eff)
    else $error("span crosses row end");

  // row end flag marks exactly the spans that reach the last column
  a_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |->
      out_chan.row_end == (({1'b0, out_chan.span_first_col} + out_chan.span_count) == cols_eff))
    else $error("row end flag mismatch");

  // span counter never passes its limit
  a_span_limit: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= SPAN_MAX)
    else $error("too many spans for one request");

endmodule

// File: tb/run_length_image_decoder_unit_tb.sv
// Testbench for the run-length image decoder: predicted row spans checked against the span channel.
`timescale 1ns / 100ps

module run_length_image_decoder_unit_tb;
  import rlid_pkg::*;

  localparam int STALL_LIMIT   = 4000;
  localparam int PRESSURE_HOLD = 400;
  localparam int RANDOM_ITEMS  = 280;
  localparam int MAX_SPANS     = 64;
  localparam int MAX_REPORTS   = 10;
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic             cmd;
    logic [ROW_W-1:0] start_row;
    logic [COL_W-1:0] start_col;
    logic [VAL_W-1:0] pixel_value;
    logic [LEN_W-1:0] run_length;
  } request_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] first_col;
    logic [CNT_W-1:0] count;
    logic [VAL_W-1:0] value;
    logic             row_end;
    logic             last;
  } span_t;

  class span_scoreboard;
    int unsigned num_rows_reg = 1;
    int unsigned num_cols_reg = 1;
    bit          mode_reg;
    int unsigned row_pos;
    int unsigned col_pos;
    bit          full;
    int unsigned rows_now;
    int unsigned cols_now;
    span_t       batch[$];
    span_t       pending_spans[$];
    int          errors;

    function void write_register(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_NUM_ROWS: num_rows_reg = data[ROW_W-1:0];
        REG_NUM_COLS: num_cols_reg = data;
        REG_MODE:     mode_reg     = data[0];
        default: ;
      endcase
    endfunction

    // Cut a pixel run into spans that stay inside one row; stop once the image is full.
    function void lay_pixels(int unsigned count, logic [VAL_W-1:0] value);
      int unsigned room;
      int unsigned take;
      span_t       s;
      while (count > 0 && !full && batch.size() < MAX_SPANS) begin
        room        = cols_now - col_pos;
        take        = (count < room) ? count : room;
        s.row       = ROW_W'(row_pos);
        s.first_col = COL_W'(col_pos);
        s.count     = CNT_W'(take);
        s.value     = value;
        s.row_end   = (col_pos + take == cols_now);
        s.last      = 1'b0;
        batch.push_back(s);
        count   -= take;
        col_pos += take;
        if (col_pos >= cols_now) begin
          col_pos = 0;
          row_pos++;
          if (row_pos >= rows_now) full = 1'b1;
        end
      end
    endfunction

    function void note_request(request_t req);
      int unsigned target;
      int unsigned here;
      span_t       s;
      rows_now = (num_rows_reg > MAX_ROWS_DEF) ? MAX_ROWS_DEF : num_rows_reg;
      cols_now = (num_cols_reg > MAX_COLS_DEF) ? MAX_COLS_DEF : num_cols_reg;
      if (cols_now == 0) cols_now = 1;
      batch.delete();
      // Dimensions may have shrunk since the last request.
      if (col_pos >= cols_now) begin
        col_pos = 0;
        row_pos++;
      end
      if (row_pos >= rows_now) full = 1'b1;
      here = row_pos * cols_now + col_pos;
      if (req.cmd == CMD_END) begin
        if (!full) lay_pixels(rows_now * cols_now - here, '0);
        row_pos = 0;
        col_pos = 0;
        full    = 1'b0;
      end else begin
        target = req.start_row * cols_now + req.start_col;
        if (mode_reg && !full && target > here) lay_pixels(target - here, '0);
        lay_pixels(req.run_length, req.pixel_value);
      end
      if (batch.size() > 0) begin
        s      = batch.pop_back();
        s.last = 1'b1;
        batch.push_back(s);
      end
      foreach (batch[i]) pending_spans.push_back(batch[i]);
    endfunction

    function void report(string what, span_t want, span_t got);
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("%s: expected row %0d col %0d count %0d value %0h row_end %0b last %0b",
                 what, want.row, want.first_col, want.count, want.value, want.row_end,
                 want.last);
        $display("    got row %0d col %0d count %0d value %0h row_end %0b last %0b",
                 got.row, got.first_col, got.count, got.value, got.row_end, got.last);
      end
    endfunction

    function void check_span(span_t got);
      span_t want;
      if (pending_spans.size() == 0) begin
        report("span with none pending", '0, got);
        return;
      end
      want = pending_spans.pop_front();
      if (got.row !== want.row || got.first_col !== want.first_col ||
          got.count !== want.count || got.value !== want.value ||
          got.row_end !== want.row_end || got.last !== want.last) begin
        report("span mismatch", want, got);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  rlid_in_if  in_bus ();
  rlid_out_if out_bus ();

  span_scoreboard sb;
  bit             pressure_req;
  bit             pressure_done;
  bit             sender_calm;
  int             idle_cycles;

  run_length_image_decoder_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_bus),
    .out_chan  (out_bus)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Check spans before noting a request taken at the same edge.
  always @(posedge clk) begin : monitor
    span_t    got;
    request_t req;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got = {out_bus.span_row, out_bus.span_first_col, out_bus.span_count,
             out_bus.span_value, out_bus.row_end, out_bus.last};
      sb.check_span(got);
    end
    if (rst_n && in_bus.valid && in_bus.ready) begin
      req = {in_bus.cmd, in_bus.start_row, in_bus.start_col, in_bus.pixel_value,
             in_bus.run_length};
      sb.note_request(req);
    end
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("run_length_image_decoder_unit: mismatch");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  initial begin : span_sink
    int hold;
    int calm;
    int r;
    hold = 0;
    calm = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (pressure_req && !pressure_done) begin
        pressure_done = 1'b1;
        hold          = PRESSURE_HOLD;
      end
      if (hold == 0 && calm == 0) begin
        r = $urandom_range(0, 99);
        if (r < 3) calm = $urandom_range(40, 120);
        else if (r < 18) hold = pick_gap();
      end
      if (hold > 0) begin
        out_bus.ready <= 1'b0;
        hold--;
      end else begin
        out_bus.ready <= 1'b1;
        if (calm > 0) calm--;
      end
    end
  end

  function automatic request_t run_req(int unsigned srow, int unsigned scol,
                                       int unsigned val, int unsigned len);
    request_t req;
    req.cmd         = CMD_RUN;
    req.start_row   = ROW_W'(srow);
    req.start_col   = COL_W'(scol);
    req.pixel_value = VAL_W'(val);
    req.run_length  = LEN_W'(len);
    return req;
  endfunction

  function automatic request_t end_req();
    request_t req;
    req             = run_req($urandom, $urandom, $urandom, $urandom);
    req.cmd         = CMD_END;
    return req;
  endfunction

  task automatic send_request(request_t req);
    int gap;
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.cmd         <= req.cmd;
    in_bus.start_row   <= req.start_row;
    in_bus.start_col   <= req.start_col;
    in_bus.pixel_value <= req.pixel_value;
    in_bus.run_length  <= req.run_length;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // Hold off until every predicted span is out and a request with no span has settled.
  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_spans.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(int unsigned rows, int unsigned cols, bit mode);
    cfg_we    <= 1'b1;
    cfg_index <= REG_NUM_ROWS;
    cfg_wdata <= CFG_W'(rows);
    @(posedge clk);
    cfg_index <= REG_NUM_COLS;
    cfg_wdata <= CFG_W'(cols);
    @(posedge clk);
    cfg_index <= REG_MODE;
    cfg_wdata <= CFG_W'(mode);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_register(REG_NUM_ROWS, CFG_W'(rows));
    sb.write_register(REG_NUM_COLS, CFG_W'(cols));
    sb.write_register(REG_MODE, CFG_W'(mode));
  endtask

  initial begin : stimulus
    int unsigned rows;
    int unsigned cols;
    int unsigned rows_eff;
    int unsigned cols_eff;
    int unsigned cursor;
    int unsigned target;
    int unsigned len;
    int unsigned sent;
    int unsigned phase;
    int unsigned n_items;
    int unsigned r;
    bit          mode;
    request_t    req;

    sb = new();
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_NUM_ROWS;
    cfg_wdata          <= '0;
    in_bus.valid       <= 1'b0;
    in_bus.cmd         <= CMD_RUN;
    in_bus.start_row   <= '0;
    in_bus.start_col   <= '0;
    in_bus.pixel_value <= '0;
    in_bus.run_length  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset dimensions: one pixel, then drop, end on a full image, end on an empty one.
    send_request(run_req(0, 0, 255, 1));
    send_request(run_req(0, 0, 8'h55, 5));
    send_request(end_req());
    send_request(end_req());
    drain();

    // Oversized registers clamp to 30 x 1024; longest run fills the image.
    configure(31, 2047, 0);
    send_request(run_req(31, 1023, 8'hAA, 32767));
    send_request(end_req());
    send_request(run_req(0, 0, 0, 0));
    send_request(run_req(0, 0, 1, 1500));
    send_request(end_req());
    drain();

    // Positional runs: gap fill, start behind, gap only, start column past the width.
    configure(3, 4, 1);
    send_request(run_req(0, 2, 7, 3));
    send_request(run_req(0, 0, 9, 2));
    send_request(run_req(2, 1, 0, 0));
    send_request(run_req(1, 9, 4, 1));
    send_request(run_req(31, 1023, 255, 32767));
    send_request(end_req());
    drain();

    // Zero rows drop everything; zero columns act as one.
    configure(0, 0, 1);
    send_request(run_req(29, 1023, 3, 5));
    send_request(end_req());
    drain();

    // Shrink the image while a row is half done.
    configure(2, 8, 0);
    send_request(run_req(0, 0, 3, 5));
    drain();
    configure(2, 3, 0);
    send_request(run_req(0, 0, 9, 4));
    send_request(end_req());
    drain();
    configure(3, 2, 0);
    send_request(run_req(0, 0, 6, 4));
    drain();
    configure(2, 2, 0);
    send_request(run_req(0, 0, 6, 1));
    send_request(end_req());
    drain();

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 80) rows = $urandom_range(1, 6);
      else if (r < 90) rows = $urandom_range(7, 31);
      else if (r < 95) rows = 0;
      else rows = 30;
      r = $urandom_range(0, 99);
      if (r < 70) cols = $urandom_range(1, 12);
      else if (r < 85) cols = $urandom_range(13, 64);
      else if (r < 95) begin
        case ($urandom_range(0, 4))
          0:       cols = 0;
          1:       cols = 1023;
          2:       cols = 1024;
          3:       cols = 1025;
          default: cols = 2047;
        endcase
      end else begin
        cols = $urandom_range(65, 2047);
      end
      mode        = $urandom_range(0, 1);
      sender_calm = ($urandom_range(0, 3) == 0);
      n_items     = $urandom_range(10, 30);
      // Let the span side sit still while requests keep coming.
      if (phase == 2) begin
        rows         = 6;
        cols         = 5;
        mode         = 1'b0;
        sender_calm  = 1'b1;
        n_items      = 30;
        pressure_req = 1'b1;
      end
      rows_eff = (rows > 30) ? 30 : rows;
      cols_eff = (cols == 0) ? 1 : ((cols > 1024) ? 1024 : cols);
      configure(rows, cols, mode);
      cursor = 0;

      for (int i = 0; i < n_items; i++) begin
        r = $urandom_range(0, 99);
        if (r < 8 || (cursor >= rows_eff * cols_eff && r < 50)) begin
          req    = end_req();
          cursor = 0;
        end else if (r < 18) begin
          req = run_req($urandom, $urandom, $urandom, $urandom);
        end else begin
          case ($urandom_range(0, 9))
            0:             len = 0;
            1, 2, 3, 4, 5, 6: len = $urandom_range(1, cols_eff);
            7, 8:          len = $urandom_range(1, 3 * cols_eff);
            default:       len = $urandom_range(1, (rows_eff + 1) * cols_eff);
          endcase
          if (len > 32767) len = 32767;
          if (mode) begin
            target = cursor;
            if ($urandom_range(0, 2) != 0) target += $urandom_range(1, 2 * cols_eff);
            req    = run_req(target / cols_eff, target % cols_eff, $urandom_range(0, 255), len);
            cursor = target + len;
          end else begin
            req    = run_req($urandom, $urandom, $urandom_range(0, 255), len);
            cursor += len;
          end
        end
        send_request(req);
        sent++;
      end
      drain();
      phase++;
    end

    drain();
    if (sb.errors == 0 && sb.pending_spans.size() == 0) begin
      $display("run_length_image_decoder_unit: match");
    end else begin
      $display("run_length_image_decoder_unit: mismatch");
    end
    $finish;
  end

endmodule
